[sv/hrhp_pkg.sv]
// hrhp_pkg: phases, result kinds, status codes and character helpers
// for the http request header parser; no dependencies
`default_nettype none
package hrhp_pkg;

  localparam logic [3:0] PH_METHOD   = 4'd0;
  localparam logic [3:0] PH_SKIP1    = 4'd1;
  localparam logic [3:0] PH_PATH     = 4'd2;
  localparam logic [3:0] PH_QUERY    = 4'd3;
  localparam logic [3:0] PH_SKIP2    = 4'd4;
  localparam logic [3:0] PH_PROTO    = 4'd5;
  localparam logic [3:0] PH_TRAIL    = 4'd6;
  localparam logic [3:0] PH_CR_TRAIL = 4'd7;
  localparam logic [3:0] PH_CR_PROTO = 4'd8;
  localparam logic [3:0] PH_HEADERS  = 4'd9;
  localparam logic [3:0] PH_BODY     = 4'd10;
  localparam logic [3:0] PH_DISCARD  = 4'd11;

  localparam logic [4:0] NAME_MATCHED = 5'd15;
  localparam logic [4:0] NAME_DIGITS  = 5'd16;
  localparam logic [4:0] NAME_DONE    = 5'd17;
  localparam logic [4:0] NAME_DEAD    = 5'd31;

  localparam logic [2:0] K_METHOD  = 3'd0;
  localparam logic [2:0] K_PATH    = 3'd1;
  localparam logic [2:0] K_QUERY   = 3'd2;
  localparam logic [2:0] K_PROTO   = 3'd3;
  localparam logic [2:0] K_BODY    = 3'd4;
  localparam logic [2:0] K_SUMMARY = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_JUNK  = 3'd1;
  localparam logic [2:0] ST_BARE  = 3'd2;
  localparam logic [2:0] ST_CR    = 3'd3;
  localparam logic [2:0] ST_EARLY = 3'd4;

  localparam int NAME_LEN = 15;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
  } res_t;

  function automatic logic is_sep(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h0;
    if (is_digit(b)) t = b - 8'h30;
    else if (b >= 8'h61 && b <= 8'h66) t = b - 8'h57;
    else if (b >= 8'h41 && b <= 8'h46) t = b - 8'h37;
    return t[3:0];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
  endfunction

  function automatic logic [7:0] name_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0: c = "c";
      4'd1: c = "o";
      4'd2: c = "n";
      4'd3: c = "t";
      4'd4: c = "e";
      4'd5: c = "n";
      4'd6: c = "t";
      4'd7: c = "-";
      4'd8: c = "l";
      4'd9: c = "e";
      4'd10: c = "n";
      4'd11: c = "g";
      4'd12: c = "t";
      4'd13: c = "h";
      4'd14: c = ":";
      default: c = 8'h0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] method_char(input logic [1:0] w, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h0;
    case (w)
      2'd0: case (p) 3'd0: c = "g"; 3'd1: c = "e"; 3'd2: c = "t"; default: c = 8'h0; endcase
      2'd1: case (p) 3'd0: c = "p"; 3'd1: c = "o"; 3'd2: c = "s"; 3'd3: c = "t";
                     default: c = 8'h0; endcase
      2'd2: case (p) 3'd0: c = "h"; 3'd1: c = "e"; 3'd2: c = "a"; 3'd3: c = "d";
                     default: c = 8'h0; endcase
      default: c = 8'h0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[sv/http_request_header_parser.sv]
// http_request_header_parser: byte-wide request line and header parser
// with a four-word result queue; depends on hrhp_pkg
//
// channel  dir  ports
// in       in   in_valid, in_stall, in_byte_in, in_end_of_buffer
// out      out  out_valid, out_stall, out_kind .. out_last_of_run
//
// one byte per cycle is taken while in_stall is low; a byte is held in the
// input register, its zero to three words enter the queue at the next edge
// and the first of them can leave once queued. the queue drains one word per
// cycle while out_stall is low, so sustained rate is one byte per cycle when
// bytes yield at most one word. input stalls when the queue would hold more
// than one word after this edge. reset is synchronous and returns the parser
// to the method phase with an empty queue.
`default_nettype none
module http_request_header_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_byte_in,
  input  wire        in_end_of_buffer,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_method_code,
  output logic [31:0] out_content_length,
  output logic [2:0] out_status,
  output logic       out_last_of_run
);
  import hrhp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LMAX = '1;
  localparam logic [LENGTH_BITS-1:0] LDIV = LMAX / 10;
  localparam logic [3:0]             LREM = 4'(LMAX % 10);
  localparam int QD = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  method_code;
    logic [31:0] content_length;
    logic [2:0]  status;
    logic        last;
  } word_t;

  // input register
  logic       iv_r;
  logic [7:0] ib_r;
  logic       ie_r;

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  cand_r, cand_nxt;
  logic [2:0]  mpos_r, mpos_nxt;
  logic [1:0]  esc_r, esc_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [4:0]  npos_r, npos_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [1:0]  let_r, let_nxt;
  logic [2:0]  err_r, err_nxt;

  word_t      q_r [QD];
  logic [1:0] qh_r, qt_r;
  logic [2:0] qc_r, qc_nxt;

  word_t      w [3];
  logic [1:0] n;

  // a newly taken byte may add three words at the following edge
  logic accept_ok;
  logic out_take;
  assign out_take  = out_valid && !out_stall;
  assign qc_nxt    = qc_r + 3'(n) - (out_take ? 3'd1 : 3'd0);
  assign accept_ok = qc_nxt <= 3'(QD - 3);
  assign in_stall  = !accept_ok;

  function automatic logic [1:0] mcode(input logic [2:0] c, input logic [2:0] p);
    logic [1:0] r;
    r = 2'd0;
    if (c[2] && p == 3'd4) r = 2'd3;
    if (c[1] && p == 3'd4) r = 2'd2;
    if (c[0] && p == 3'd3) r = 2'd1;
    return r;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [3:0] d;
    logic [4:0] p;
    logic [1:0] mc;
    logic [31:0] lsat;
    logic pp_do;
    logic [7:0] pp_b;
    b = ib_r;
    d = b[3:0];
    p = npos_r;
    phase_nxt = phase_r; cand_nxt = cand_r; mpos_nxt = mpos_r; esc_nxt = esc_r;
    first_nxt = first_r; npos_nxt = npos_r; len_nxt = len_r; let_nxt = let_r;
    err_nxt = err_r;
    n = 2'd0;
    pp_do = 1'b0; pp_b = b;
    for (int i = 0; i < 3; i++) w[i] = '0;
    case (phase_r)
      PH_METHOD: begin
        if (is_sep(b)) phase_nxt = PH_SKIP1;
        else begin
          for (int i = 0; i < 3; i++)
            if (!(mpos_r < ((i == 0) ? 3'd3 : 3'd4) &&
                  to_lower(b) == method_char(2'(i), mpos_r)))
              cand_nxt[i] = 1'b0;
          if (mpos_r < 3'd7) mpos_nxt = mpos_r + 3'd1;
          w[0].kind = K_METHOD; w[0].data_byte = b; n = 2'd1;
        end
      end
      PH_SKIP1: begin
        if (!is_sep(b)) begin
          phase_nxt = PH_PATH; pp_do = 1'b1;
        end
      end
      PH_PATH: begin
        if (esc_r == 2'd1) begin
          if (is_hex(b)) begin
            esc_nxt = 2'd2; first_nxt = b;
          end else begin
            esc_nxt = 2'd0;
            w[0].kind = K_PATH; w[0].data_byte = 8'h25; n = 2'd1; pp_do = 1'b1;
          end
        end else if (esc_r == 2'd2) begin
          esc_nxt = 2'd0;
          if (is_hex(b)) begin
            w[0].kind = K_PATH; w[0].data_byte = {hex_val(first_r), hex_val(b)}; n = 2'd1;
          end else begin
            w[0].kind = K_PATH; w[0].data_byte = 8'h25;
            w[1].kind = K_PATH; w[1].data_byte = first_r; n = 2'd2; pp_do = 1'b1;
          end
        end else pp_do = 1'b1;
      end
      PH_QUERY: begin
        if (is_sep(b)) phase_nxt = PH_SKIP2;
        else begin
          w[0].kind = K_QUERY; w[0].data_byte = b; n = 2'd1;
        end
      end
      PH_SKIP2: begin
        if (!is_sep(b)) begin
          phase_nxt = PH_PROTO; w[0].kind = K_PROTO; w[0].data_byte = b; n = 2'd1;
        end
      end
      PH_PROTO: begin
        if (b == 8'h20 || b == 8'h09) phase_nxt = PH_TRAIL;
        else if (b == 8'h0a) begin
          err_nxt = ST_BARE; phase_nxt = PH_DISCARD; w[0].kind = K_SUMMARY; n = 2'd1;
        end else if (b == 8'h0d) phase_nxt = PH_CR_PROTO;
        else begin
          w[0].kind = K_PROTO; w[0].data_byte = b; n = 2'd1;
        end
      end
      PH_TRAIL: begin
        if (b == 8'h0d) phase_nxt = PH_CR_TRAIL;
        else if (b != 8'h20 && b != 8'h09) begin
          err_nxt = ST_JUNK; phase_nxt = PH_DISCARD; w[0].kind = K_SUMMARY; n = 2'd1;
        end
      end
      PH_CR_TRAIL, PH_CR_PROTO: begin
        if (b == 8'h0a) begin
          phase_nxt = PH_HEADERS; let_nxt = 2'd2; npos_nxt = 5'd0;
        end else begin
          err_nxt = (phase_r == PH_CR_TRAIL) ? ST_JUNK : ST_CR;
          phase_nxt = PH_DISCARD; w[0].kind = K_SUMMARY; n = 2'd1;
        end
      end
      PH_HEADERS: begin
        if (let_r == 2'd3 && b == 8'h0a) begin
          err_nxt = ST_OK; phase_nxt = PH_BODY; w[0].kind = K_SUMMARY; n = 2'd1;
        end else if (b == 8'h0a && let_r[0]) begin
          let_nxt = 2'd2; npos_nxt = 5'd0;
        end else begin
          if (b == 8'h0d) let_nxt = (let_r == 2'd2) ? 2'd3 : 2'd1;
          else let_nxt = 2'd0;
          p = npos_r;
          if (npos_r < NAME_MATCHED) begin
            if (to_lower(b) == name_char(npos_r[3:0])) begin
              p = npos_r + 5'd1;
              if (p == NAME_MATCHED) len_nxt = '0;
            end else p = NAME_DEAD;
          end else if (npos_r == NAME_MATCHED) begin
            if (is_digit(b)) begin
              len_nxt = LENGTH_BITS'(d); p = NAME_DIGITS;
            end else if (b != 8'h20 && b != 8'h09) p = NAME_DONE;
          end else if (npos_r == NAME_DIGITS) begin
            if (is_digit(b)) begin
              if (len_r > LDIV || (len_r == LDIV && d > LREM)) len_nxt = LMAX;
              else len_nxt = (len_r << 3) + (len_r << 1) + LENGTH_BITS'(d);
            end else p = NAME_DONE;
          end
          npos_nxt = p;
        end
      end
      PH_BODY: begin
        w[0].kind = K_BODY; w[0].data_byte = b; n = 2'd1;
      end
      default: ;
    endcase
    if (pp_do) begin
      if (is_sep(pp_b)) phase_nxt = PH_SKIP2;
      else if (pp_b == 8'h3f) phase_nxt = PH_QUERY;
      else if (pp_b == 8'h25) begin
        esc_nxt = 2'd1;
      end else begin
        w[n].kind = K_PATH; w[n].data_byte = pp_b; n = n + 2'd1;
      end
    end
    if (ie_r && phase_nxt != PH_BODY && phase_nxt != PH_DISCARD) begin
      err_nxt = ST_EARLY;
      for (int i = 0; i < 3; i++) w[i] = '0;
      w[0].kind = K_SUMMARY; n = 2'd1;
    end
    mc = mcode(cand_nxt, mpos_nxt);
    if (LENGTH_BITS > 32) lsat = (len_nxt > LENGTH_BITS'(32'hFFFFFFFF)) ? 32'hFFFFFFFF
                                                                          : 32'(len_nxt);
    else lsat = 32'(len_nxt);
    for (int i = 0; i < 3; i++) begin
      if (w[i].kind == K_SUMMARY) begin
        w[i].method_code = mc; w[i].content_length = lsat; w[i].status = err_nxt;
      end
      w[i].last = (2'(i) == n - 2'd1);
    end
    if (!iv_r) n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0; qh_r <= '0; qt_r <= '0; qc_r <= '0;
      phase_r <= PH_METHOD; cand_r <= 3'b111; mpos_r <= '0; esc_r <= '0;
      first_r <= '0; npos_r <= '0; len_r <= '0; let_r <= '0; err_r <= '0;
    end else begin
      iv_r <= in_valid && accept_ok;
      if (iv_r) begin
        if (ie_r) begin
          phase_r <= PH_METHOD; cand_r <= 3'b111; mpos_r <= '0; esc_r <= '0;
          first_r <= '0; npos_r <= '0; len_r <= '0; let_r <= '0; err_r <= '0;
        end else begin
          phase_r <= phase_nxt; cand_r <= cand_nxt; mpos_r <= mpos_nxt; esc_r <= esc_nxt;
          first_r <= first_nxt; npos_r <= npos_nxt; len_r <= len_nxt; let_r <= let_nxt;
          err_r <= err_nxt;
        end
      end
      for (int i = 0; i < 3; i++)
        if (2'(i) < n) q_r[2'(qt_r + 2'(i))] <= w[i];
      qt_r <= qt_r + n;
      if (out_take) qh_r <= qh_r + 2'd1;
      qc_r <= qc_nxt;
    end
    if (in_valid && accept_ok) begin
      ib_r <= in_byte_in; ie_r <= in_end_of_buffer;
    end
  end

  assign out_valid          = qc_r != 3'd0;
  assign out_kind           = q_r[qh_r].kind;
  assign out_data_byte      = q_r[qh_r].data_byte;
  assign out_method_code    = q_r[qh_r].method_code;
  assign out_content_length = q_r[qh_r].content_length;
  assign out_status         = q_r[qh_r].status;
  assign out_last_of_run    = q_r[qh_r].last;

  a_qc_bound: assert property (@(posedge clk) disable iff (!rst_n) qc_r <= 3'(QD))
    else $error("queue overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable({out_kind, out_data_byte}))
    else $error("stalled word changed");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_DISCARD) else $error("bad phase");
endmodule
`default_nettype wire

[tb/hrhp_checker.sv]
// hrhp_checker: watches both channels of the http request header parser,
// predicts result words per accepted byte and compares them; uses hrhp_pkg
module hrhp_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [7:0]  in_byte_in,
  input  wire         in_end_of_buffer,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [2:0]  out_kind,
  input  wire  [7:0]  out_data_byte,
  input  wire  [1:0]  out_method_code,
  input  wire  [31:0] out_content_length,
  input  wire  [2:0]  out_status,
  input  wire         out_last_of_run,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hrhp_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [1:0]  mcode;
    logic [31:0] clen;
    logic [2:0]  status;
    logic        last;
  } word_t;

  word_t words_due[$];
  word_t fresh[$];

  logic [3:0]  phase;
  logic [2:0]  cand;
  logic [2:0]  mpos;
  logic [1:0]  esc;
  logic [7:0]  esc_first;
  logic [4:0]  npos;
  logic [31:0] clen_acc;
  logic [1:0]  lend;
  logic [2:0]  err;

  function automatic bit sep_c(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d;
  endfunction
  function automatic bit dig_c(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic bit hex_c(logic [7:0] b);
    return dig_c(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction
  function automatic logic [3:0] nib(logic [7:0] b);
    if (dig_c(b)) return 4'(b - "0");
    if (b >= "a" && b <= "f") return 4'(b - "a" + 10);
    if (b >= "A" && b <= "F") return 4'(b - "A" + 10);
    return 0;
  endfunction
  function automatic logic [7:0] low_c(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic [7:0] meth_ch(int w, int p);
    string s;
    s = (w == 0) ? "get" : (w == 1) ? "post" : "head";
    return (p < s.len()) ? s[p] : 8'h0;
  endfunction

  function automatic logic [1:0] meth_now();
    int lens[3];
    lens = '{3, 4, 4};
    for (int i = 0; i < 3; i++)
      if (cand[i] && mpos == lens[i]) return 2'(i + 1);
    return 0;
  endfunction

  task automatic emit(logic [2:0] k, logic [7:0] d);
    word_t w;
    w = '0;
    w.kind = k;
    w.data = d;
    fresh.push_back(w);
  endtask

  task automatic emit_summary();
    word_t w;
    w = '0;
    w.kind = K_SUMMARY;
    w.mcode = meth_now();
    w.clen = clen_acc;
    w.status = err;
    fresh.push_back(w);
  endtask

  task automatic abort_line(logic [2:0] code);
    err = code;
    phase = PH_DISCARD;
    emit_summary();
  endtask

  task automatic parse_reset();
    phase = PH_METHOD;
    cand = 3'b111;
    mpos = 0;
    esc = 0;
    esc_first = 0;
    npos = 0;
    clen_acc = 0;
    lend = 0;
    err = 0;
  endtask

  task automatic path_byte(logic [7:0] b);
    if (sep_c(b)) phase = PH_SKIP2;
    else if (b == "?") phase = PH_QUERY;
    else if (b == "%") esc = 1;
    else emit(K_PATH, b);
  endtask

  task automatic header_step(logic [7:0] b);
    string nm;
    logic [4:0] p;
    logic [35:0] t;
    nm = "content-length:";
    p = npos;
    if (b == 8'h0a && lend[0]) begin
      lend = 2;
      npos = 0;
      return;
    end
    if (b == 8'h0d) lend = (lend == 2) ? 3 : 1;
    else lend = 0;
    if (p < NAME_MATCHED) begin
      if (low_c(b) == nm[p]) begin
        p++;
        if (p == NAME_MATCHED) clen_acc = 0;
      end else p = NAME_DEAD;
    end else if (p == NAME_MATCHED) begin
      if (dig_c(b)) begin
        clen_acc = 32'(b - "0");
        p = NAME_DIGITS;
      end else if (b != 8'h20 && b != 8'h09) p = NAME_DONE;
    end else if (p == NAME_DIGITS) begin
      if (dig_c(b)) begin
        t = clen_acc * 36'd10 + 36'(b - "0");
        clen_acc = (t > 36'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
      end else p = NAME_DONE;
    end
    npos = p;
  endtask

  task automatic predict(logic [7:0] b, logic eob);
    fresh.delete();
    case (phase)
      PH_METHOD: begin
        if (sep_c(b)) phase = PH_SKIP1;
        else begin
          for (int i = 0; i < 3; i++)
            if (!(mpos < ((i == 0) ? 3 : 4) && low_c(b) == meth_ch(i, mpos)))
              cand[i] = 1'b0;
          if (mpos < 7) mpos++;
          emit(K_METHOD, b);
        end
      end
      PH_SKIP1: if (!sep_c(b)) begin
        phase = PH_PATH;
        path_byte(b);
      end
      PH_PATH: begin
        if (esc == 1) begin
          if (hex_c(b)) begin
            esc = 2;
            esc_first = b;
          end else begin
            esc = 0;
            emit(K_PATH, "%");
            path_byte(b);
          end
        end else if (esc == 2) begin
          esc = 0;
          if (hex_c(b)) emit(K_PATH, {nib(esc_first), nib(b)});
          else begin
            emit(K_PATH, "%");
            emit(K_PATH, esc_first);
            path_byte(b);
          end
        end else path_byte(b);
      end
      PH_QUERY: if (sep_c(b)) phase = PH_SKIP2; else emit(K_QUERY, b);
      PH_SKIP2: if (!sep_c(b)) begin
        phase = PH_PROTO;
        emit(K_PROTO, b);
      end
      PH_PROTO: begin
        if (b == 8'h20 || b == 8'h09) phase = PH_TRAIL;
        else if (b == 8'h0a) abort_line(ST_BARE);
        else if (b == 8'h0d) phase = PH_CR_PROTO;
        else emit(K_PROTO, b);
      end
      PH_TRAIL: begin
        if (b == 8'h0d) phase = PH_CR_TRAIL;
        else if (b != 8'h20 && b != 8'h09) abort_line(ST_JUNK);
      end
      PH_CR_TRAIL, PH_CR_PROTO: begin
        if (b == 8'h0a) begin
          phase = PH_HEADERS;
          lend = 2;
          npos = 0;
        end else abort_line(phase == PH_CR_TRAIL ? ST_JUNK : ST_CR);
      end
      PH_HEADERS: begin
        if (lend == 3 && b == 8'h0a) begin
          err = ST_OK;
          phase = PH_BODY;
          emit_summary();
        end else header_step(b);
      end
      PH_BODY: emit(K_BODY, b);
      default: ;
    endcase
    if (eob) begin
      if (phase != PH_BODY && phase != PH_DISCARD) begin
        err = ST_EARLY;
        fresh.delete();
        emit_summary();
      end
      parse_reset();
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) words_due.push_back(fresh[i]);
  endtask

  assign pending = words_due.size();

  always @(posedge clk) begin
    word_t got, want;
    if (!rst_n) begin
      parse_reset();
      words_due.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_kind, out_data_byte, out_method_code, out_content_length, out_status,
               out_last_of_run};
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = words_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected k%0d d%h m%0d l%0d s%0d e%0b", $time,
                     want.kind, want.data, want.mcode, want.clen, want.status, want.last);
            $display("%0t:            actual k%0d d%h m%0d l%0d s%0d e%0b", $time,
                     got.kind, got.data, got.mcode, got.clen, got.status, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict(in_byte_in, in_end_of_buffer);
    end
  end
endmodule

[tb/tb_top.sv]
// tb_top: stimulus and verdict for http_request_header_parser
// depends on hrhp_pkg, the parser and hrhp_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_end_of_buffer = 0, out_stall = 0;
  logic [7:0] in_byte_in = 0;
  logic in_stall, out_valid, out_last_of_run;
  logic [2:0] out_kind, out_status;
  logic [7:0] out_data_byte;
  logic [1:0] out_method_code;
  logic [31:0] out_content_length;
  int fail_count, pending, cycles = 0;
  int sent = 0;
  bit calm = 0;
  byte unsigned req_bytes[$];

  always #1 clk = ~clk;

  http_request_header_parser dut (.*);
  hrhp_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL http_request_header_parser");
      $finish;
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (calm) out_stall <= 0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if ($urandom_range(9) == 0) begin
      stall_left <= $urandom_range(7);
      out_stall <= 1;
    end else out_stall <= 0;
  end

  task automatic send_byte(byte unsigned b, bit eob);
    if (!calm && $urandom_range(9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1;
    in_byte_in <= b;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_request(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_queue();
    foreach (req_bytes[i]) send_byte(req_bytes[i], i == req_bytes.size() - 1);
    req_bytes.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endtask

  function automatic string rnd_tok(int n);
    string s, alpha;
    alpha = "aZ09/%Fx?.-_";
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(alpha[$urandom_range(alpha.len() - 1)])};
    return s;
  endfunction

  task automatic build_random();
    string meths[6];
    int r;
    meths = '{"GET", "post", "HeAd", "GETX", "PUT", "pos"};
    r = $urandom_range(9);
    if (r == 0) begin
      repeat ($urandom_range(1, 12)) req_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    add_str({meths[$urandom_range(5)], ($urandom_range(3) == 0) ? " \t " : " "});
    add_str({"/", rnd_tok($urandom_range(0, 6))});
    if ($urandom_range(2) == 0) add_str({"?", rnd_tok($urandom_range(1, 4))});
    add_str(" HTTP/1.1");
    case ($urandom_range(7))
      0: add_str(" x");
      1: add_str("\n");
      2: add_str("\rz");
      3: add_str(" \t\r\n");
      default: add_str("\r\n");
    endcase
    if ($urandom_range(3) == 0) begin
      send_queue();
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(1)) add_str(
          $sformatf("content-LENGTH: %0d\r\n", $urandom_range(0, 100000)));
      else add_str("Host: h\n\r\r\n");
    end
    if ($urandom_range(9) == 0) add_str("Content-Length:99999999999\r\n");
    if ($urandom_range(4) != 0) begin
      add_str("\r\n");
      repeat ($urandom_range(1, 4)) req_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_request("GET /a%41%g%4?q=1 HTTP/1.0\r\nContent-Length: 4294967296\r\n\r\nxy");
    send_request(" /x HTTP/1.1 \r\n\r\n\xff");
    send_request("POST /%zz HTTP/1.1\nz");
    send_request("head /p HTTP\rqq");
    send_request("GET /p HTTP/1.1 junk");
    send_request("GET /p H");
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    while (sent < 250) begin
      calm = (sent > 200 && sent < 225);
      build_random();
      if (req_bytes.size() > 0) send_queue();
    end
    calm = 1;
    repeat (2) begin
      build_random();
      if (req_bytes.size() > 0) send_queue();
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("PASS http_request_header_parser");
    else $display("FAIL http_request_header_parser");
    $finish;
  end
endmodule
